[src/fcsm_pkg.sv]
// shared constants and types for the flash command state machine
package fcsm_pkg;

    localparam int ADDR_BITS_DEF  = 21;
    localparam int BLOCK_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_PRESENT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_PROTECT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SEGMENT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_LOG2     = 2'd3;

    localparam logic       FLASH_PRESENT_RST = 1'b1;
    localparam logic       WRITE_PROTECT_RST = 1'b0;
    localparam logic [7:0] BASE_SEGMENT_RST  = 8'd32;
    localparam logic [4:0] SIZE_LOG2_RST     = 5'd21;

    // command bytes
    localparam logic [7:0] CMD_ARM        = 8'h50;
    localparam logic [7:0] CMD_PROG_SETUP = 8'h10;
    localparam logic [7:0] CMD_ERASE_SET  = 8'h20;
    localparam logic [7:0] CMD_ERASE_GO   = 8'hD0;
    localparam logic [7:0] CMD_RESET      = 8'hFF;
    localparam logic [7:0] ERASED_BYTE    = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ARMED   = 3'd1,
        PH_ONE10   = 3'd2,
        PH_ERSETUP = 3'd3,
        PH_ERASED  = 3'd4
    } phase_t;

endpackage

[src/flash_command_state_machine.sv]
// flash command state machine: byte program and block erase on one byte-wide memory
// the result strobe (done) is registered from the decide state entered on the edge that takes start
// a new write is taken only back in idle, after the memory read and the check and write back of the last one
// a block erase keeps busy high while it walks the whole block, one byte per cycle
// through the memory write port; the result is not held off by the receiver
// reset clears phase, countdown and status and loads config defaults; memory is not cleared
module flash_command_state_machine #(
    parameter int ADDR_BITS  = fcsm_pkg::ADDR_BITS_DEF,
    parameter int BLOCK_BITS = fcsm_pkg::BLOCK_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             cfg_we,
    input  logic [fcsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fcsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [23:0]                      bus_address,
    input  logic [7:0]                       write_data,
    output logic                             done,
    output logic                             byte_programmed,
    output logic                             block_erased,
    output logic [5:0]                       block_number,
    output logic                             status_all_ones,
    output logic [2:0]                       phase_code,
    output logic [1:0]                       program_count,
    output logic [7:0]                       cell_value
);

    localparam int STORE_DEPTH = 1 << ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] BLOCK_MASK = ADDR_BITS'((1 << BLOCK_BITS) - 1);
    localparam logic [BLOCK_BITS-1:0] CNT_LAST = '1;
    localparam logic [7:0] ERASED_BYTE_C = fcsm_pkg::ERASED_BYTE;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ERASE
    } state_t;

    logic [7:0] flash_mem [0:STORE_DEPTH-1];

    state_t                state_reg, state_next;
    logic                  present_reg, protect_reg;
    logic [7:0]            base_reg;
    logic [4:0]            size_reg;
    fcsm_pkg::phase_t      phase_reg, phase_next;
    logic [1:0]            count_reg, count_next;
    logic                  status_reg, status_next;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [7:0]            data_reg;
    logic [7:0]            mem_rdata_reg;
    logic [BLOCK_BITS-1:0] erase_cnt_reg, erase_cnt_next;
    logic                  done_reg;
    logic                  prog_reg, prog_next;
    logic                  erased_reg, erased_next;
    logic [5:0]            blk_reg, blk_next;
    logic [7:0]            cell_reg, cell_next;

    logic [23:0]          rebased;
    logic [4:0]           size_eff;
    logic [ADDR_BITS-1:0] size_mask;
    logic [ADDR_BITS-1:0] masked_addr;
    logic                 accept;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [7:0]           mem_wdata;
    logic [23:0]          addr_wide;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // rebase to the flash window and mask to the size in use
    always_comb
    begin
        rebased  = bus_address - {base_reg, 16'h0000};
        size_eff = (size_reg > 5'(ADDR_BITS)) ? 5'(ADDR_BITS) : size_reg;
        for (int i = 0; i < ADDR_BITS; i++)
        begin
            size_mask[i] = (5'(i) < size_eff);
        end
        masked_addr = rebased[ADDR_BITS-1:0] & size_mask;
    end

    assign addr_wide = 24'(addr_reg) >> BLOCK_BITS;

    always_comb
    begin
        logic [1:0] cnt_tmp;
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        erase_cnt_next = erase_cnt_reg;
        prog_next      = 1'b0;
        erased_next    = 1'b0;
        blk_next       = addr_wide[5:0];
        cell_next      = mem_rdata_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = data_reg;
        cnt_tmp        = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                if (present_reg && !protect_reg)
                begin
                    if (count_reg != 2'd0)
                    begin
                        if (mem_rdata_reg == ERASED_BYTE_C || count_reg == 2'd1)
                        begin
                            prog_next = 1'b1;
                            mem_we    = 1'b1;
                            cell_next = data_reg;
                        end
                        else
                        begin
                            cnt_tmp = count_reg - 2'd1;
                        end
                        count_next  = cnt_tmp - 2'd1;
                        status_next = 1'b1;
                    end
                    else
                    begin
                        case (data_reg)
                            fcsm_pkg::CMD_ARM:
                            begin
                                phase_next = fcsm_pkg::PH_ARMED;
                            end
                            fcsm_pkg::CMD_PROG_SETUP:
                            begin
                                if (phase_reg == fcsm_pkg::PH_ARMED)
                                begin
                                    phase_next = fcsm_pkg::PH_ONE10;
                                end
                                else if (phase_reg == fcsm_pkg::PH_ONE10)
                                begin
                                    count_next = 2'd2;
                                    phase_next = fcsm_pkg::PH_ARMED;
                                end
                            end
                            fcsm_pkg::CMD_ERASE_SET:
                            begin
                                if (phase_reg == fcsm_pkg::PH_ARMED)
                                begin
                                    phase_next = fcsm_pkg::PH_ERSETUP;
                                end
                            end
                            fcsm_pkg::CMD_ERASE_GO:
                            begin
                                if (phase_reg == fcsm_pkg::PH_ERSETUP)
                                begin
                                    phase_next     = fcsm_pkg::PH_ERASED;
                                    status_next    = 1'b1;
                                    erased_next    = 1'b1;
                                    cell_next      = ERASED_BYTE_C;
                                    erase_cnt_next = '0;
                                    state_next     = ST_ERASE;
                                end
                            end
                            fcsm_pkg::CMD_RESET:
                            begin
                                if (phase_reg == fcsm_pkg::PH_ARMED)
                                begin
                                    count_next  = 2'd0;
                                    status_next = 1'b0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_ERASE:
            begin
                // walk the block one byte per cycle
                mem_we         = 1'b1;
                mem_waddr      = (addr_reg & ~BLOCK_MASK) | ADDR_BITS'(erase_cnt_reg);
                mem_wdata      = ERASED_BYTE_C;
                erase_cnt_next = erase_cnt_reg + 1'b1;
                if (erase_cnt_reg == CNT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            flash_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= flash_mem[masked_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= masked_addr;
            data_reg <= write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= fcsm_pkg::PH_IDLE;
            count_reg     <= 2'd0;
            status_reg    <= 1'b0;
            erase_cnt_reg <= '0;
            done_reg      <= 1'b0;
            prog_reg      <= 1'b0;
            erased_reg    <= 1'b0;
            blk_reg       <= 6'd0;
            cell_reg      <= 8'd0;
            present_reg   <= fcsm_pkg::FLASH_PRESENT_RST;
            protect_reg   <= fcsm_pkg::WRITE_PROTECT_RST;
            base_reg      <= fcsm_pkg::BASE_SEGMENT_RST;
            size_reg      <= fcsm_pkg::SIZE_LOG2_RST;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            erase_cnt_reg <= erase_cnt_next;
            done_reg      <= (state_reg == ST_DECIDE);
            if (state_reg == ST_DECIDE)
            begin
                prog_reg   <= prog_next;
                erased_reg <= erased_next;
                blk_reg    <= blk_next;
                cell_reg   <= cell_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    fcsm_pkg::CFG_FLASH_PRESENT: present_reg <= cfg_data[0];
                    fcsm_pkg::CFG_WRITE_PROTECT: protect_reg <= cfg_data[0];
                    fcsm_pkg::CFG_BASE_SEGMENT:  base_reg    <= cfg_data;
                    fcsm_pkg::CFG_SIZE_LOG2:     size_reg    <= cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign done            = done_reg;
    assign byte_programmed = prog_reg;
    assign block_erased    = erased_reg;
    assign block_number    = blk_reg;
    assign cell_value      = cell_reg;
    assign status_all_ones = status_reg;
    assign phase_code      = phase_reg;
    assign program_count   = count_reg;

endmodule

[src/fcsm_checker.sv]
// port-level checks for the flash command state machine, bound to the top level
module fcsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        byte_programmed,
    input logic        block_erased,
    input logic        status_all_ones,
    input logic [2:0]  phase_code,
    input logic [7:0]  write_data,
    input logic [7:0]  cell_value
);

    // every result comes from an earlier matching input transfer
    a_done_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a matching input transfer");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after an input transfer");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(byte_programmed && block_erased))
        else $error("program and erase in the same result");

    a_erase_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && block_erased) |-> (cell_value == fcsm_pkg::ERASED_BYTE
            && phase_code == fcsm_pkg::PH_ERASED && status_all_ones))
        else $error("erase result inconsistent");

    a_program_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && byte_programmed) |-> (cell_value == $past(write_data, 2) && status_all_ones))
        else $error("programmed cell does not hold the written byte");

endmodule

bind flash_command_state_machine fcsm_checker u_fcsm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .byte_programmed (byte_programmed),
    .block_erased    (block_erased),
    .status_all_ones (status_all_ones),
    .phase_code      (phase_code),
    .write_data      (write_data),
    .cell_value      (cell_value)
);

[dv/tb_flash_command_state_machine.sv]
// self-checking testbench for the flash command state machine
module tb_flash_command_state_machine;

    localparam int ADDR_BITS  = fcsm_pkg::ADDR_BITS_DEF;
    localparam int BLOCK_BITS = fcsm_pkg::BLOCK_BITS_DEF;
    localparam int NUM_BLOCKS = 1 << (ADDR_BITS - BLOCK_BITS);

    typedef struct {
        bit [23:0] bus;
        bit [7:0]  data;
    } bus_write_t;

    typedef struct {
        bit       programmed;
        bit       erased;
        bit [5:0] blk;
        bit       status;
        bit [2:0] phase;
        bit [1:0] count;
        bit [7:0] cell_byte;
        bit       cell_known;
    } flash_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [fcsm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [fcsm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic [23:0]                      bus_address = '0;
    logic [7:0]                       write_data = '0;
    logic                             busy;
    logic                             done;
    logic                             byte_programmed;
    logic                             block_erased;
    logic [5:0]                       block_number;
    logic                             status_all_ones;
    logic [2:0]                       phase_code;
    logic [1:0]                       program_count;
    logic [7:0]                       cell_value;

    flash_command_state_machine u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .bus_address     (bus_address),
        .write_data      (write_data),
        .done            (done),
        .byte_programmed (byte_programmed),
        .block_erased    (block_erased),
        .block_number    (block_number),
        .status_all_ones (status_all_ones),
        .phase_code      (phase_code),
        .program_count   (program_count),
        .cell_value      (cell_value)
    );

    always #5 clk = ~clk;

    // shadow of the device: configuration, command state and memory image
    bit                cfg_present = fcsm_pkg::FLASH_PRESENT_RST;
    bit                cfg_protect = fcsm_pkg::WRITE_PROTECT_RST;
    bit [7:0]          cfg_base    = fcsm_pkg::BASE_SEGMENT_RST;
    bit [4:0]          cfg_size    = fcsm_pkg::SIZE_LOG2_RST;
    fcsm_pkg::phase_t  cmd_phase   = fcsm_pkg::PH_IDLE;
    bit [1:0]          prog_count  = 2'd0;
    bit                status_ones = 1'b0;
    bit [7:0]          flash_img [0:(1 << ADDR_BITS)-1];
    // a block holds defined bytes only once it has been erased
    bit                block_known [0:NUM_BLOCKS-1];

    bus_write_t    pending_writes[$];
    flash_result_t expected_results[$];

    int unsigned sent_count = 0;
    int unsigned taken_count = 0;
    int unsigned queued_items = 0;
    int unsigned results_seen = 0;
    int unsigned error_count = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned erase_budget = 8;
    bit [31:0]   last_prog = 32'd0;

    function automatic int unsigned eff_size();
        return (cfg_size > ADDR_BITS) ? ADDR_BITS : cfg_size;
    endfunction

    function automatic flash_result_t flash_write_step(bit [23:0] bus, bit [7:0] data);
        flash_result_t r;
        bit [31:0]     a;
        int unsigned   blk;
        a = ({8'd0, bus} - ({24'd0, cfg_base} << 16)) & 32'hFF_FFFF;
        a = a & ((32'd1 << eff_size()) - 32'd1);
        blk = a >> BLOCK_BITS;
        r.programmed = 1'b0;
        r.erased = 1'b0;
        if (cfg_present && !cfg_protect)
        begin
            if (prog_count != 2'd0)
            begin
                if (flash_img[a] == fcsm_pkg::ERASED_BYTE || prog_count == 2'd1)
                begin
                    flash_img[a] = data;
                    r.programmed = 1'b1;
                end
                else
                begin
                    // a refused program costs one extra step of the countdown
                    prog_count = prog_count - 2'd1;
                end
                prog_count = prog_count - 2'd1;
                status_ones = 1'b1;
            end
            else
            begin
                case (data)
                    fcsm_pkg::CMD_ARM: cmd_phase = fcsm_pkg::PH_ARMED;
                    fcsm_pkg::CMD_PROG_SETUP:
                    begin
                        if (cmd_phase == fcsm_pkg::PH_ARMED)
                            cmd_phase = fcsm_pkg::PH_ONE10;
                        else if (cmd_phase == fcsm_pkg::PH_ONE10)
                        begin
                            prog_count = 2'd2;
                            cmd_phase = fcsm_pkg::PH_ARMED;
                        end
                    end
                    fcsm_pkg::CMD_ERASE_SET:
                    begin
                        if (cmd_phase == fcsm_pkg::PH_ARMED)
                            cmd_phase = fcsm_pkg::PH_ERSETUP;
                    end
                    fcsm_pkg::CMD_ERASE_GO:
                    begin
                        if (cmd_phase == fcsm_pkg::PH_ERSETUP)
                        begin
                            cmd_phase = fcsm_pkg::PH_ERASED;
                            status_ones = 1'b1;
                            for (int i = 0; i < (1 << BLOCK_BITS); i++)
                                flash_img[(blk << BLOCK_BITS) | i] = fcsm_pkg::ERASED_BYTE;
                            block_known[blk] = 1'b1;
                            r.erased = 1'b1;
                        end
                    end
                    fcsm_pkg::CMD_RESET:
                    begin
                        if (cmd_phase == fcsm_pkg::PH_ARMED)
                        begin
                            prog_count = 2'd0;
                            status_ones = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        r.blk = blk[5:0];
        r.status = status_ones;
        r.phase = cmd_phase;
        r.count = prog_count;
        r.cell_byte = flash_img[a];
        r.cell_known = block_known[blk];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= 100)
            $display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    endtask

    // mostly short gaps, a few long ones, and now and then a burst with none
    function automatic int unsigned next_gap();
        int unsigned r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 2)
        begin
            burst_left = $urandom_range(40, 15);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    always @(negedge clk)
    begin : driver
        bus_write_t w;
        if (!rst_n)
            start <= 1'b0;
        else if (start && taken_count != sent_count)
            start <= 1'b1;
        else if (gap_left > 0)
        begin
            gap_left--;
            start <= 1'b0;
        end
        else if (pending_writes.size() != 0)
        begin
            w = pending_writes.pop_front();
            bus_address <= w.bus;
            write_data <= w.data;
            start <= 1'b1;
            sent_count++;
            gap_left = next_gap();
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        flash_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", 32'd1, 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (byte_programmed !== want.programmed)
                        report_mismatch("byte_programmed", byte_programmed, want.programmed);
                    if (block_erased !== want.erased)
                        report_mismatch("block_erased", block_erased, want.erased);
                    if (block_number !== want.blk)
                        report_mismatch("block_number", block_number, want.blk);
                    if (status_all_ones !== want.status)
                        report_mismatch("status_all_ones", status_all_ones, want.status);
                    if (phase_code !== want.phase)
                        report_mismatch("phase_code", phase_code, want.phase);
                    if (program_count !== want.count)
                        report_mismatch("program_count", program_count, want.count);
                    // cells read before their block is first erased hold no defined value
                    if (want.cell_known && cell_value !== want.cell_byte)
                        report_mismatch("cell_value", cell_value, want.cell_byte);
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(flash_write_step(bus_address, write_data));
                taken_count++;
            end
        end
    end

    task automatic push_write(bit [23:0] bus, bit [7:0] data);
        bus_write_t w;
        w.bus = bus;
        w.data = data;
        pending_writes.push_back(w);
        queued_items++;
    endtask

    task automatic wait_drained();
        while (pending_writes.size() != 0 || taken_count != sent_count ||
               expected_results.size() != 0 || busy || start)
            @(posedge clk);
    endtask

    // masked address inside a reachable block, erased unless fresh is asked for
    function automatic bit [31:0] pick_masked(bit fresh);
        int unsigned lg;
        int unsigned nblk;
        int unsigned b;
        int unsigned c;
        lg = eff_size();
        nblk = (lg > BLOCK_BITS) ? (1 << (lg - BLOCK_BITS)) : 1;
        b = 0;
        for (int t = 0; t < 64; t++)
        begin
            c = $urandom_range(nblk - 1);
            if (block_known[c] != fresh)
            begin
                b = c;
                break;
            end
        end
        if (lg >= BLOCK_BITS)
            return (b << BLOCK_BITS) | $urandom_range((1 << BLOCK_BITS) - 1);
        return $urandom & ((32'd1 << lg) - 32'd1);
    endfunction

    // bus address that rebases and masks to a, with random bits above the mask
    function automatic bit [23:0] to_bus(bit [31:0] a);
        bit [31:0] v;
        v = a + ({24'd0, cfg_base} << 16) + ($urandom << eff_size());
        return v[23:0];
    endfunction

    // an erase walks a whole block, so look at the live state before sending one
    task automatic push_erase_go();
        wait_drained();
        if (cfg_present && !cfg_protect && prog_count == 2'd0 &&
            cmd_phase == fcsm_pkg::PH_ERSETUP)
        begin
            if (erase_budget == 0 || $urandom_range(3) != 0)
                push_write(to_bus(pick_masked(1'b0)), fcsm_pkg::CMD_ARM);
            else
            begin
                erase_budget--;
                push_write(to_bus(pick_masked($urandom_range(1))), fcsm_pkg::CMD_ERASE_GO);
            end
        end
        else
            push_write(to_bus(pick_masked(1'b0)), fcsm_pkg::CMD_ERASE_GO);
    endtask

    task automatic write_reg(logic [fcsm_pkg::CFG_INDEX_W-1:0] idx,
                             logic [fcsm_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            fcsm_pkg::CFG_FLASH_PRESENT: cfg_present = val[0];
            fcsm_pkg::CFG_WRITE_PROTECT: cfg_protect = val[0];
            fcsm_pkg::CFG_BASE_SEGMENT:  cfg_base = val;
            fcsm_pkg::CFG_SIZE_LOG2:     cfg_size = val[4:0];
            default: ;
        endcase
    endtask

    task automatic set_flash_config(bit present, bit protect, bit [7:0] base, bit [4:0] size);
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(fcsm_pkg::CFG_FLASH_PRESENT, {7'd0, present});
        write_reg(fcsm_pkg::CFG_WRITE_PROTECT, {7'd0, protect});
        write_reg(fcsm_pkg::CFG_BASE_SEGMENT, base);
        write_reg(fcsm_pkg::CFG_SIZE_LOG2, {3'd0, size});
        last_prog = 32'd0;
    endtask

    task automatic run_random(int unsigned quota);
        int unsigned kind;
        int unsigned stop;
        bit [7:0]    b;
        bit [31:0]   a;
        stop = queued_items + quota;
        while (queued_items < stop)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                push_write(to_bus(pick_masked(1'b0)), fcsm_pkg::CMD_ARM);
                push_write(to_bus(pick_masked(1'b0)), fcsm_pkg::CMD_PROG_SETUP);
                push_write(to_bus(pick_masked(1'b0)), fcsm_pkg::CMD_PROG_SETUP);
                // reusing a programmed cell hits the refused-program path
                a = ($urandom_range(2) == 0) ? last_prog : pick_masked(1'b0);
                push_write(to_bus(a), 8'($urandom));
                if ($urandom_range(4) != 0)
                    push_write(to_bus(($urandom_range(1) == 0) ? a : pick_masked(1'b0)),
                               8'($urandom));
                last_prog = a;
            end
            else if (kind < 55)
            begin
                push_write(to_bus(pick_masked(1'b0)), fcsm_pkg::CMD_ARM);
                push_write(to_bus(pick_masked(1'b0)), fcsm_pkg::CMD_ERASE_SET);
                push_erase_go();
            end
            else if (kind < 63)
            begin
                push_write(to_bus(pick_masked(1'b0)), fcsm_pkg::CMD_ARM);
                push_write(to_bus(pick_masked(1'b0)), fcsm_pkg::CMD_RESET);
            end
            else
            begin
                case ($urandom_range(7))
                    0: b = fcsm_pkg::CMD_ARM;
                    1: b = fcsm_pkg::CMD_PROG_SETUP;
                    2: b = fcsm_pkg::CMD_ERASE_SET;
                    3: b = fcsm_pkg::CMD_ERASE_GO;
                    4: b = fcsm_pkg::CMD_RESET;
                    default: b = 8'($urandom);
                endcase
                if (b == fcsm_pkg::CMD_ERASE_GO)
                    push_erase_go();
                else
                    push_write(to_bus(pick_masked(1'b0)), b);
            end
        end
    endtask

    initial
    begin : stimulus
        int unsigned quota;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset mapping: base 0x20, 2 MB; erase the bottom and top blocks first
        push_write(24'h200123, fcsm_pkg::CMD_ARM);
        push_write(24'h200123, fcsm_pkg::CMD_ERASE_SET);
        push_write(24'h204567, fcsm_pkg::CMD_ERASE_GO);
        push_write(24'h000000, fcsm_pkg::CMD_ARM);
        push_write(24'h20ABCD, fcsm_pkg::CMD_ERASE_SET);
        push_write(24'h3FFFFF, fcsm_pkg::CMD_ERASE_GO);
        push_write(24'hFFFFFF, 8'h51);
        push_write(24'h200000, fcsm_pkg::CMD_PROG_SETUP);
        push_write(24'h200000, fcsm_pkg::CMD_ARM);
        push_write(24'h200000, fcsm_pkg::CMD_PROG_SETUP);
        push_write(24'h200000, fcsm_pkg::CMD_PROG_SETUP);
        push_write(24'h200000, 8'h00);
        push_write(24'h200000, 8'hA5);
        push_write(24'h200000, fcsm_pkg::CMD_ARM);
        push_write(24'h200000, fcsm_pkg::CMD_PROG_SETUP);
        push_write(24'h200000, fcsm_pkg::CMD_PROG_SETUP);
        push_write(24'h200000, 8'h3C);
        push_write(24'h200000, fcsm_pkg::CMD_RESET);
        push_write(24'h3FFFFF, fcsm_pkg::CMD_ERASE_SET);
        push_write(24'h3FFFFF, fcsm_pkg::CMD_PROG_SETUP);
        push_write(24'h3FFFFF, fcsm_pkg::CMD_RESET);
        push_write(24'h3FFFFE, fcsm_pkg::CMD_ARM);
        push_write(24'h200002, fcsm_pkg::CMD_ERASE_GO);

        for (int p = 0; p < 10; p++)
        begin
            quota = 200;
            case (p)
                0: set_flash_config(1'b1, 1'b0, 8'h00, 5'd16);
                1:
                begin
                    set_flash_config(1'b0, 1'b0, 8'h20, 5'd21);
                    quota = 60;
                end
                2:
                begin
                    set_flash_config(1'b1, 1'b1, 8'hFF, 5'd22);
                    quota = 60;
                end
                3: set_flash_config(1'b1, 1'b0, 8'hFF, 5'd22);
                4: set_flash_config(1'b1, 1'b0, 8'h7F, 5'd31);
                5: set_flash_config(1'b1, 1'b0, 8'hA5, 5'd0);
                6: set_flash_config(1'b1, 1'b0, 8'h20, 5'd21);
                default: set_flash_config(1'b1, $urandom_range(9) == 0, 8'($urandom),
                                          5'($urandom_range(21, 16)));
            endcase
            run_random(quota);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never seen", 32'd0, expected_results.size());
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
